FILE: rtl/core/tsjc_pkg.sv
// tsjc_pkg: shared types, widths and register codes for the two-slope curve core.
// No dependencies.

package tsjc_pkg;

  localparam int unsigned SCALE_W   = 15;  // full scale, knee, run
  localparam int unsigned GAIN_W    = 16;  // Q8.8 inner gain
  localparam int unsigned CFG_W     = 16;  // config data bus
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned KG_W      = SCALE_W + 1 + GAIN_W;   // knee * gain
  localparam int unsigned RISE_W    = KG_W - 8;               // outer rise
  localparam int unsigned KGR_W     = KG_W + SCALE_W + 1;     // knee * gain * run
  localparam int unsigned FIXED_LAT = 7;   // pipeline stages besides the divider row

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_SCALE = 2'd0,
    REG_KNEE       = 2'd1,
    REG_GAIN       = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_INNER,
    MODE_OUTER
  } mode_e;

  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

  // signed numerator width before the divide
  function automatic int unsigned num_width(int unsigned data_bits);
    int unsigned a;
    a = data_bits + 1 + RISE_W + 8;
    return ((a > KGR_W) ? a : KGR_W) + 1;
  endfunction

endpackage

FILE: rtl/core/tsjc_front.sv
// tsjc_front: five-stage front end; builds the dividend magnitude, divisor and sign.
// Depends on tsjc_pkg.

module tsjc_front #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic signed [DATA_BITS-1:0]                sample_i,
  input  logic        [tsjc_pkg::SCALE_W-1:0]        full_scale_i,
  input  logic        [tsjc_pkg::SCALE_W-1:0]        knee_i,
  input  logic signed [tsjc_pkg::GAIN_W-1:0]         gain_i,
  output tsjc_pkg::ctl_t                             ctl_o,
  output logic [tsjc_pkg::num_width(DATA_BITS)-9:0]  mag_o,
  output logic [tsjc_pkg::SCALE_W-1:0]               div_o
);

  import tsjc_pkg::*;

  localparam int unsigned DB    = DATA_BITS;
  localparam int unsigned CW    = DB + SCALE_W;
  localparam int unsigned XG_W  = DB + GAIN_W;
  localparam int unsigned PR_W  = DB + 1 + RISE_W;
  localparam int unsigned NUM_W = num_width(DATA_BITS);

  // stage 1: classify, knee * gain
  logic [DB-1:0]             x_u, ax, dm_d;
  logic [CW-1:0]             ax_w, k_w, dm_w;
  logic                      pass, inner;
  mode_e                     mode_d;
  logic signed [KG_W-1:0]    kg_d;

  logic                      v1_q, sneg1_q;
  mode_e                     mode1_q;
  logic signed [DB-1:0]      x1_q;
  logic [SCALE_W-1:0]        m1_q, run1_q;
  logic signed [KG_W-1:0]    kg1_q;
  logic [DB-1:0]             dm1_q;
  logic signed [GAIN_W-1:0]  g1_q;

  assign x_u   = sample_i;
  assign ax    = x_u[DB-1] ? (~x_u + DB'(1)) : x_u;
  assign ax_w  = CW'(ax);
  assign k_w   = CW'(knee_i);
  assign dm_w  = ax_w - k_w;
  assign dm_d  = dm_w[DB-1:0];
  assign inner = (ax_w <= k_w);
  assign pass  = (full_scale_i == '0) || (knee_i == '0) || (gain_i == '0) ||
                 (knee_i >= full_scale_i);
  assign mode_d = pass ? MODE_PASS : (inner ? MODE_INNER : MODE_OUTER);
  assign kg_d   = $signed({1'b0, knee_i}) * gain_i;

  always_ff @(posedge clk_i) begin
    mode1_q <= mode_d;
    sneg1_q <= x_u[DB-1];
    x1_q    <= sample_i;
    m1_q    <= full_scale_i;
    run1_q  <= full_scale_i - knee_i;
    kg1_q   <= kg_d;
    dm1_q   <= dm_d;
    g1_q    <= gain_i;
  end

  // stage 2: rise, knee*gain*run, inner product
  logic signed [KG_W-1:0]   t;
  logic [KG_W-1:0]          tb;
  logic signed [RISE_W-1:0] rise_d;
  logic signed [KGR_W-1:0]  kgr_d;
  logic signed [XG_W-1:0]   xg_d;

  logic                     v2_q, sneg2_q;
  mode_e                    mode2_q;
  logic signed [DB-1:0]     x2_q;
  logic [SCALE_W-1:0]       run2_q;
  logic signed [RISE_W-1:0] rise2_q;
  logic signed [KGR_W-1:0]  kgr2_q;
  logic signed [XG_W-1:0]   xg2_q;
  logic [DB-1:0]            dm2_q;

  assign t      = $signed({{(KG_W-SCALE_W-8){1'b0}}, m1_q, 8'b0}) - kg1_q;
  // bias negatives so the shift truncates toward zero
  assign tb     = t + KG_W'({8{t[KG_W-1]}});
  assign rise_d = $signed(tb[KG_W-1:8]);
  assign kgr_d  = kg1_q * $signed({1'b0, run1_q});
  assign xg_d   = x1_q * g1_q;

  always_ff @(posedge clk_i) begin
    mode2_q <= mode1_q;
    sneg2_q <= sneg1_q;
    x2_q    <= x1_q;
    run2_q  <= run1_q;
    rise2_q <= rise_d;
    kgr2_q  <= kgr_d;
    xg2_q   <= xg_d;
    dm2_q   <= dm1_q;
  end

  // stage 3: distance past knee times rise
  logic signed [PR_W-1:0]  pr_d;

  logic                    v3_q, sneg3_q;
  mode_e                   mode3_q;
  logic signed [DB-1:0]    x3_q;
  logic [SCALE_W-1:0]      run3_q;
  logic signed [KGR_W-1:0] kgr3_q;
  logic signed [XG_W-1:0]  xg3_q;
  logic signed [PR_W-1:0]  pr3_q;

  assign pr_d = $signed({1'b0, dm2_q}) * rise2_q;

  always_ff @(posedge clk_i) begin
    mode3_q <= mode2_q;
    sneg3_q <= sneg2_q;
    x3_q    <= x2_q;
    run3_q  <= run2_q;
    kgr3_q  <= kgr2_q;
    xg3_q   <= xg2_q;
    pr3_q   <= pr_d;
  end

  // stage 4: outer numerator (sign of sample factored out), pick by segment
  logic signed [NUM_W-1:0] n_d, sv_d;

  logic                    v4_q, sneg4_q, outer4_q;
  logic [SCALE_W-1:0]      run4_q;
  logic signed [NUM_W-1:0] sv4_q;

  assign n_d = NUM_W'(kgr3_q) + (NUM_W'(pr3_q) <<< 8);

  always_comb begin
    case (mode3_q)
      MODE_OUTER: sv_d = n_d;
      MODE_INNER: sv_d = NUM_W'(xg3_q);
      default:    sv_d = NUM_W'(x3_q) <<< 8;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sneg4_q  <= sneg3_q;
    outer4_q <= (mode3_q == MODE_OUTER);
    run4_q   <= run3_q;
    sv4_q    <= sv_d;
  end

  // stage 5: magnitude / 256, divisor, result sign
  logic [NUM_W-1:0]   sv4_u, mag_full;

  logic               v5_q, neg5_q;
  logic [NUM_W-9:0]   mag5_q;
  logic [SCALE_W-1:0] div5_q;

  assign sv4_u    = sv4_q;
  assign mag_full = sv4_u[NUM_W-1] ? (~sv4_u + NUM_W'(1)) : sv4_u;

  always_ff @(posedge clk_i) begin
    neg5_q <= sv4_u[NUM_W-1] ^ (outer4_q & sneg4_q);
    mag5_q <= mag_full[NUM_W-1:8];
    div5_q <= outer4_q ? run4_q : SCALE_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign ctl_o = '{valid: v5_q, neg: neg5_q};
  assign mag_o = mag5_q;
  assign div_o = div5_q;

endmodule

FILE: rtl/core/tsjc_cell.sv
// tsjc_cell: one restoring-division step; produces one quotient bit per word.
// Depends on tsjc_pkg.

module tsjc_cell #(
  parameter int unsigned DQ_W = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsjc_pkg::ctl_t                ctl_i,
  input  logic                          ovf_i,
  input  logic [tsjc_pkg::SCALE_W-1:0]  rem_i,
  input  logic [DQ_W-1:0]               dq_i,
  input  logic [tsjc_pkg::SCALE_W-1:0]  div_i,
  output tsjc_pkg::ctl_t                ctl_o,
  output logic                          ovf_o,
  output logic [tsjc_pkg::SCALE_W-1:0]  rem_o,
  output logic [DQ_W-1:0]               dq_o,
  output logic [tsjc_pkg::SCALE_W-1:0]  div_o
);

  import tsjc_pkg::*;

  logic [SCALE_W:0]   part;
  logic [SCALE_W+1:0] trial;
  logic               ge;
  logic [SCALE_W-1:0] rem_d;
  logic [DQ_W-1:0]    dq_d;

  logic               valid_q, neg_q, ovf_q;
  logic [SCALE_W-1:0] rem_q, div_q;
  logic [DQ_W-1:0]    dq_q;

  // dividend bits shift out the top of dq, quotient bits shift in at the bottom
  assign part  = {rem_i, dq_i[DQ_W-1]};
  assign trial = {1'b0, part} - {2'b00, div_i};
  assign ge    = ~trial[SCALE_W+1];
  assign rem_d = ge ? trial[SCALE_W-1:0] : part[SCALE_W-1:0];
  assign dq_d  = {dq_i[DQ_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= ctl_i.neg;
    ovf_q <= ovf_i;
    rem_q <= rem_d;
    dq_q  <= dq_d;
    div_q <= div_i;
  end

  assign ctl_o = '{valid: valid_q, neg: neg_q};
  assign ovf_o = ovf_q;
  assign rem_o = rem_q;
  assign dq_o  = dq_q;
  assign div_o = div_q;

endmodule

FILE: rtl/core/two_slope_joystick_curve_core.sv
// two_slope_joystick_curve_core: top level; config registers, front end, divider row, output.
// Depends on tsjc_pkg, tsjc_front, tsjc_cell.
//
// Usage:
//   Input: a sample word is taken at each rising edge with start_i high and busy_o
//   low. busy_o is always low; one word can be started every cycle.
//   Output: shaped_o and clipped_o hold a result for exactly one cycle, flagged by
//   done_o. Results leave in input order. There is no back-pressure: the receiver
//   must take each result in the cycle it is shown.
//   Pipeline: five front-end stages, one divide setup stage, one divider cell per
//   quotient bit, one output stage.
//   Throughput: one word per cycle, set by the row of DATA_BITS divider cells that
//   each retire one quotient bit and pass the word on every cycle.
//   Config: cfg_we_i writes cfg_wdata_i into the register picked by cfg_idx_i
//   (0 full scale, 1 knee, 2 inner gain); other indexes are ignored. Write only
//   while no word is in flight.
//   Reset: all config registers clear to zero (pass-through) and the pipeline is
//   emptied; no result appears until a word is started.

module two_slope_joystick_curve_core #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [DATA_BITS-1:0]       sample_i,
  output logic signed [DATA_BITS-1:0]       shaped_o,
  output logic                              clipped_o,
  output logic                              done_o,
  input  logic                              cfg_we_i,
  input  logic [tsjc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tsjc_pkg::CFG_W-1:0]        cfg_wdata_i
);

  import tsjc_pkg::*;

  localparam int unsigned DB    = DATA_BITS;
  localparam int unsigned MAG_W = num_width(DATA_BITS) - 8;
  localparam int unsigned HI_W  = MAG_W - DB;

  // config registers
  logic [SCALE_W-1:0]       fs_q, knee_q;
  logic signed [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= '0;
      knee_q <= '0;
      gain_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FULL_SCALE: fs_q   <= cfg_wdata_i[SCALE_W-1:0];
        REG_KNEE:       knee_q <= cfg_wdata_i[SCALE_W-1:0];
        REG_GAIN:       gain_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front end
  ctl_t               f_ctl;
  logic [MAG_W-1:0]   f_mag;
  logic [SCALE_W-1:0] f_div;

  tsjc_front #(
    .DATA_BITS(DATA_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start_i & ~busy_o),
    .sample_i     (sample_i),
    .full_scale_i (fs_q),
    .knee_i       (knee_q),
    .gain_i       (gain_q),
    .ctl_o        (f_ctl),
    .mag_o        (f_mag),
    .div_o        (f_div)
  );

  // divide setup: quotient of 2**DB or more saturates, else the top part is below
  // the divisor and seeds the remainder
  logic [HI_W-1:0]    mag_hi;
  logic               pv_q, pneg_q, povf_q;
  logic [SCALE_W-1:0] prem_q, pdiv_q;
  logic [DB-1:0]      pdq_q;

  assign mag_hi = f_mag[MAG_W-1:DB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= f_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pneg_q <= f_ctl.neg;
    povf_q <= (mag_hi >= HI_W'(f_div));
    prem_q <= mag_hi[SCALE_W-1:0];
    pdq_q  <= f_mag[DB-1:0];
    pdiv_q <= f_div;
  end

  // divider row
  ctl_t               c_ctl [DB+1];
  logic               c_ovf [DB+1];
  logic [SCALE_W-1:0] c_rem [DB+1];
  logic [DB-1:0]      c_dq  [DB+1];
  logic [SCALE_W-1:0] c_div [DB+1];

  assign c_ctl[0] = '{valid: pv_q, neg: pneg_q};
  assign c_ovf[0] = povf_q;
  assign c_rem[0] = prem_q;
  assign c_dq[0]  = pdq_q;
  assign c_div[0] = pdiv_q;

  for (genvar i = 0; i < DB; i++) begin : g_cell
    tsjc_cell #(
      .DQ_W(DB)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (c_ctl[i]),
      .ovf_i  (c_ovf[i]),
      .rem_i  (c_rem[i]),
      .dq_i   (c_dq[i]),
      .div_i  (c_div[i]),
      .ctl_o  (c_ctl[i+1]),
      .ovf_o  (c_ovf[i+1]),
      .rem_o  (c_rem[i+1]),
      .dq_o   (c_dq[i+1]),
      .div_o  (c_div[i+1])
    );
  end

  // sign and saturation
  ctl_t          o_ctl;
  logic [DB-1:0] q, val_d;
  logic          clip_d;
  logic          done_q, clipped_q;
  logic [DB-1:0] shaped_q;

  assign o_ctl = c_ctl[DB];
  assign q     = c_dq[DB];

  always_comb begin
    if (o_ctl.neg) begin
      clip_d = c_ovf[DB] | (q[DB-1] & (|q[DB-2:0]));
      val_d  = clip_d ? {1'b1, {(DB-1){1'b0}}} : (~q + DB'(1));
    end else begin
      clip_d = c_ovf[DB] | q[DB-1];
      val_d  = clip_d ? {1'b0, {(DB-1){1'b1}}} : q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      clipped_q <= 1'b0;
    end else begin
      done_q    <= o_ctl.valid;
      clipped_q <= o_ctl.valid & clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shaped_q <= val_d;
  end

  assign busy_o    = 1'b0;
  assign done_o    = done_q;
  assign clipped_o = clipped_q;
  assign shaped_o  = $signed(shaped_q);

endmodule

FILE: rtl/core/tsjc_checker.sv
// tsjc_checker: port-level checks on the two-slope curve core, bound to the top level.
// Depends on tsjc_pkg and two_slope_joystick_curve_core.

module tsjc_checker #(
  parameter int unsigned DATA_BITS = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic [DATA_BITS-1:0] shaped_o,
  input logic                 clipped_o,
  input logic                 done_o
);

  import tsjc_pkg::*;

  localparam int unsigned LAT = DATA_BITS + FIXED_LAT;
  localparam logic [DATA_BITS-1:0] SAT_HI = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic [DATA_BITS-1:0] SAT_LO = {1'b1, {(DATA_BITS-1){1'b0}}};

  // every started word comes out after the fixed latency
  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("word started but no result after fixed latency");

  // no result without a matching start
  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##LAT !done_o)
    else $error("result without a started word");

  a_clip_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clipped_o |-> done_o)
    else $error("clipped flag outside a result cycle");

  a_clip_is_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |-> (shaped_o == SAT_HI || shaped_o == SAT_LO))
    else $error("clipped result not at a rail");

endmodule

bind two_slope_joystick_curve_core tsjc_checker #(
  .DATA_BITS(DATA_BITS)
) u_tsjc_checker (.*);
